>>> design/oahs_pkg.sv
// Shared constants and types for the open-addressing hash set unit.
`default_nettype none

package oahs_pkg;

  // Field widths of the request, response and configuration registers.
  localparam int OP_W     = 2;
  localparam int KEY_W    = 64;
  localparam int STATUS_W = 3;
  localparam int COUNT_W  = 11;
  localparam int SIZE_W   = 4;
  localparam int STRIDE_W = 10;
  localparam int HASH_W   = 32;
  localparam int LG_W     = 5;

  // Configuration port shape.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 10;

  // Parameter defaults.
  localparam int DEF_TABLE_DEPTH = 1024;
  localparam int DEF_KEY_BYTES   = 8;

  // Hash constants.
  localparam logic [HASH_W-1:0] HASH_SEED   = 32'd104729;
  localparam logic [HASH_W-1:0] HASH_MASK31 = 32'h7fff_ffff;

  // Register reset values.
  localparam logic [SIZE_W-1:0]   SIZE_LOG2_RESET = 4'd10;
  localparam logic [STRIDE_W-1:0] STRIDE_RESET    = 10'd3;

  // Register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_SIZE_LOG2    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PROBE_STRIDE = 1'd1;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ADD   = 2'd0;
  localparam logic [OP_W-1:0] OP_TEST  = 2'd1;
  localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

  // Status codes.
  localparam logic [STATUS_W-1:0] ST_ADDED     = 3'd0;
  localparam logic [STATUS_W-1:0] ST_PRESENT   = 3'd1;
  localparam logic [STATUS_W-1:0] ST_FOUND     = 3'd2;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
  localparam logic [STATUS_W-1:0] ST_NULL      = 3'd4;
  localparam logic [STATUS_W-1:0] ST_FULL      = 3'd5;
  localparam logic [STATUS_W-1:0] ST_CLEARED   = 3'd6;

  // Hash unit command and answer.
  typedef struct packed {
    logic             start;
    logic [KEY_W-1:0] key;
  } hash_req_t;

  typedef struct packed {
    logic              done;
    logic [HASH_W-1:0] value;
  } hash_rsp_t;

endpackage

`default_nettype wire

>>> design/oahs_if.sv
// Request and response channel interfaces of the hash set unit.
`default_nettype none

interface oahs_req_if import oahs_pkg::*; ();
  logic             valid;
  logic             ready;
  logic [OP_W-1:0]  operation;
  logic [KEY_W-1:0] key;

  modport source (output valid, output operation, output key, input ready);
  modport sink   (input valid, input operation, input key, output ready);
endinterface

interface oahs_rsp_if import oahs_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [COUNT_W-1:0]  count;

  modport source (output valid, output status, output count, input ready);
  modport sink   (input valid, input status, input count, output ready);
endinterface

`default_nettype wire

>>> design/oahs_hash.sv
// Iterative shift-add-xor hash, one key byte per cycle.
`default_nettype none

module oahs_hash import oahs_pkg::*; #(
  parameter int KEY_BYTES = DEF_KEY_BYTES
) (
  input  wire       clk,
  input  wire       rst,
  input  hash_req_t req,
  output hash_rsp_t rsp
);

  localparam int CNT_W = $clog2(KEY_BYTES + 1);

  logic              busy;
  logic              done;
  logic [CNT_W-1:0]  byte_cnt;
  logic [KEY_W-1:0]  key_sh;
  logic [HASH_W-1:0] acc;
  logic [HASH_W-1:0] sra;
  logic [HASH_W-1:0] acc_next;

  // One round: r ^= (r << 5) + byte + (r >>> 2).
  always_comb begin
    sra      = {acc[HASH_W-1], acc[HASH_W-1], acc[HASH_W-1:2]};
    acc_next = acc ^ ((acc << 5) + {24'd0, key_sh[7:0]} + sra);
  end

  // Control of the byte walk.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy     <= 1'b0;
      done     <= 1'b0;
      byte_cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy     <= 1'b1;
        byte_cnt <= '0;
      end else if (busy) begin
        byte_cnt <= byte_cnt + CNT_W'(1);
        if (byte_cnt == CNT_W'(KEY_BYTES - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath of the accumulator and the key shifter.
  always_ff @(posedge clk) begin
    if (req.start) begin
      acc    <= HASH_SEED;
      key_sh <= req.key;
    end else if (busy) begin
      acc    <= acc_next;
      key_sh <= key_sh >> 8;
    end
  end

  assign rsp.done  = done;
  assign rsp.value = acc & HASH_MASK31;

endmodule

`default_nettype wire

>>> design/oahs_table.sv
// Slot memory: a used flag and a key per slot, registered read.
`default_nettype none

module oahs_table import oahs_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int ADDR_W      = $clog2(DEF_TABLE_DEPTH)
) (
  input  wire              clk,
  input  wire              we,
  input  wire [ADDR_W-1:0] addr,
  input  wire [KEY_W:0]    wdata,
  output logic [KEY_W:0]   rdata
);

  logic [KEY_W:0] mem [TABLE_DEPTH];

  // Single address, write and registered read.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

>>> design/open_addressing_hash_set_unit.sv
// Top level of the open-addressing hash set unit with its probe sequencer.
//
// A set of nonzero 64-bit keys in an open-addressed table of TABLE_DEPTH slots. Each request
// adds a key, tests membership or clears the table, and yields one response with a status and
// the stored count. One request is handled at a time. An add or test of a nonzero key is
// accepted, hashed in the byte-serial hash unit (one round per key byte, then the hand-over
// of the hash), probed slot by slot (slot memory read, then compare), and answered with the
// response. A null key, a test on an empty set or an unknown operation goes from acceptance
// straight to the response. A clear sweeps the slot memory one slot a cycle over all
// TABLE_DEPTH slots, then responds. After reset the same sweep runs before the first
// request is accepted; configuration writes are taken throughout.
`default_nettype none

module open_addressing_hash_set_unit import oahs_pkg::*; #(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int KEY_BYTES   = DEF_KEY_BYTES
) (
  input  wire                  clk,
  input  wire                  rst,
  oahs_req_if.sink             req,
  oahs_rsp_if.source           rsp,
  input  wire                  cfg_we,
  input  wire [CFG_IDX_W-1:0]  cfg_index,
  input  wire [CFG_DATA_W-1:0] cfg_data
);

  localparam int ADDR_W = $clog2(TABLE_DEPTH);
  localparam int MAX_LG = $clog2(TABLE_DEPTH + 1) - 1;
  localparam int SUM_W  = (ADDR_W > STRIDE_W) ? ADDR_W : STRIDE_W;
  localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);

  // Sequencer states.
  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_HASH  = 3'd2;
  localparam logic [2:0] S_READ  = 3'd3;
  localparam logic [2:0] S_CMP   = 3'd4;
  localparam logic [2:0] S_OUT   = 3'd5;

  logic [2:0]          state;
  logic [OP_W-1:0]     op_r;
  logic [KEY_W-1:0]    key_r;
  logic [ADDR_W-1:0]   home;
  logic [ADDR_W-1:0]   idx;
  logic [ADDR_W-1:0]   clr_addr;
  logic                clr_result;
  logic [CNT_W-1:0]    stored_count;
  logic [STATUS_W-1:0] status_r;
  logic [SIZE_W-1:0]   size_log2;
  logic [STRIDE_W-1:0] probe_stride;

  logic [LG_W-1:0]     lg_eff;
  logic [ADDR_W-1:0]   mask;
  logic [SUM_W-1:0]    idx_sum;
  logic [ADDR_W-1:0]   idx_adv;
  logic                req_fire;
  logic                rsp_fire;

  hash_req_t           hreq;
  hash_rsp_t           hrsp;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_addr;
  logic [KEY_W:0]      mem_wdata;
  logic [KEY_W:0]      mem_rdata;
  logic                slot_used;
  logic [KEY_W-1:0]    slot_key;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      size_log2    <= SIZE_LOG2_RESET;
      probe_stride <= STRIDE_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SIZE_LOG2:    size_log2    <= cfg_data[SIZE_W-1:0];
        REG_PROBE_STRIDE: probe_stride <= cfg_data[STRIDE_W-1:0];
        default:          ;
      endcase
    end
  end

  // Active table size, saturated into the range the memory can hold.
  always_comb begin
    if (size_log2 == '0) begin
      lg_eff = LG_W'(1);
    end else if ({1'b0, size_log2} > LG_W'(MAX_LG)) begin
      lg_eff = LG_W'(MAX_LG);
    end else begin
      lg_eff = {1'b0, size_log2};
    end
    for (int i = 0; i < ADDR_W; i++) begin
      mask[i] = (LG_W'(i) < lg_eff);
    end
  end

  // Next slot of the probe chain.
  assign idx_sum = SUM_W'(idx) + SUM_W'(probe_stride);
  assign idx_adv = idx_sum[ADDR_W-1:0] & mask;

  assign req_fire  = req.valid && req.ready;
  assign rsp_fire  = rsp.valid && rsp.ready;
  assign slot_used = mem_rdata[KEY_W];
  assign slot_key  = mem_rdata[KEY_W-1:0];

  // Hash unit command.
  always_comb begin
    hreq.start = 1'b0;
    hreq.key   = req.key;
    if (req_fire && req.key != '0) begin
      if (req.operation == OP_ADD ||
          (req.operation == OP_TEST && stored_count != '0)) begin
        hreq.start = 1'b1;
      end
    end
  end

  oahs_hash #(
    .KEY_BYTES (KEY_BYTES)
  ) u_hash (
    .clk (clk),
    .rst (rst),
    .req (hreq),
    .rsp (hrsp)
  );

  // Slot memory port: sweep writes during a clear, insert writes on an add.
  always_comb begin
    mem_addr  = idx;
    mem_we    = 1'b0;
    mem_wdata = {1'b1, key_r};
    if (state == S_CLEAR) begin
      mem_addr  = clr_addr;
      mem_we    = 1'b1;
      mem_wdata = '0;
    end else if (state == S_CMP && op_r == OP_ADD && !slot_used) begin
      mem_we = 1'b1;
    end
  end

  oahs_table #(
    .TABLE_DEPTH (TABLE_DEPTH),
    .ADDR_W      (ADDR_W)
  ) u_table (
    .clk   (clk),
    .we    (mem_we),
    .addr  (mem_addr),
    .wdata (mem_wdata),
    .rdata (mem_rdata)
  );

  // Probe sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      clr_result   <= 1'b0;
      stored_count <= '0;
    end else begin
      case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == ADDR_W'(TABLE_DEPTH - 1)) begin
            stored_count <= '0;
            status_r     <= ST_CLEARED;
            state        <= clr_result ? S_OUT : S_IDLE;
          end
        end
        S_IDLE: begin
          if (req_fire) begin
            op_r  <= req.operation;
            key_r <= req.key;
            case (req.operation)
              OP_ADD: begin
                if (req.key == '0) begin
                  status_r <= ST_NULL;
                  state    <= S_OUT;
                end else begin
                  state <= S_HASH;
                end
              end
              OP_TEST: begin
                if (req.key == '0 || stored_count == '0) begin
                  status_r <= ST_NOT_FOUND;
                  state    <= S_OUT;
                end else begin
                  state <= S_HASH;
                end
              end
              OP_CLEAR: begin
                clr_addr   <= '0;
                clr_result <= 1'b1;
                state      <= S_CLEAR;
              end
              default: begin
                status_r <= ST_NOT_FOUND;
                state    <= S_OUT;
              end
            endcase
          end
        end
        S_HASH: begin
          if (hrsp.done) begin
            home  <= hrsp.value[ADDR_W-1:0] & mask;
            idx   <= hrsp.value[ADDR_W-1:0] & mask;
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_CMP;
        end
        S_CMP: begin
          if (!slot_used) begin
            // Empty slot ends the chain; an add claims it.
            if (op_r == OP_ADD) begin
              stored_count <= stored_count + CNT_W'(1);
              status_r     <= ST_ADDED;
            end else begin
              status_r <= ST_NOT_FOUND;
            end
            state <= S_OUT;
          end else if (slot_key == key_r) begin
            status_r <= (op_r == OP_ADD) ? ST_PRESENT : ST_FOUND;
            state    <= S_OUT;
          end else if (idx_adv == home) begin
            // Chain came back to its home slot without a hit.
            status_r <= (op_r == OP_ADD) ? ST_FULL : ST_NOT_FOUND;
            state    <= S_OUT;
          end else begin
            idx   <= idx_adv;
            state <= S_READ;
          end
        end
        S_OUT: begin
          if (rsp_fire) begin
            clr_result <= 1'b0;
            state      <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Channel outputs.
  assign req.ready  = (state == S_IDLE);
  assign rsp.valid  = (state == S_OUT);
  assign rsp.status = status_r;
  assign rsp.count  = COUNT_W'(stored_count);

endmodule

`default_nettype wire

>>> sim/tb.sv
// Self-checking testbench for the open-addressing hash set unit.
`timescale 1ns / 1ps

module tb;
  import oahs_pkg::*;

  localparam int MAX_LG       = $clog2(DEF_TABLE_DEPTH);
  localparam int RANDOM_ITEMS = 1250;
  localparam int PHASES       = 14;
  localparam int CALM_FIRST   = 600;
  localparam int CALM_LAST    = 800;

  // Operation code that the unit does not define.
  localparam logic [OP_W-1:0] OP_UNKNOWN = 2'd3;

  typedef struct {
    logic [OP_W-1:0]  op;
    logic [KEY_W-1:0] key;
  } set_req_t;

  typedef struct {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  count;
  } outcome_t;

  logic clk;
  logic rst;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  oahs_req_if req_ch ();
  oahs_rsp_if rsp_ch ();

  open_addressing_hash_set_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req       (req_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // Shadow of the table and of the configuration registers.
  logic [KEY_W-1:0]    tbl_key  [DEF_TABLE_DEPTH];
  bit                  tbl_used [DEF_TABLE_DEPTH];
  logic [COUNT_W-1:0]  stored;
  logic [SIZE_W-1:0]   size_cfg;
  logic [STRIDE_W-1:0] stride_cfg;

  set_req_t         req_q     [$];
  outcome_t         outcome_q [$];
  logic [KEY_W-1:0] key_pool  [$];

  int accepted_reqs;
  int checked_rsps;
  int failures;

  always #6 clk = ~clk;

  // Shift-add-xor hash over the eight key bytes, low byte first.
  function automatic logic [HASH_W-1:0] key_hash(input logic [KEY_W-1:0] k);
    logic [HASH_W-1:0] r;
    logic [HASH_W-1:0] b;
    logic [HASH_W-1:0] sra;
    r = HASH_SEED;
    for (int i = 0; i < DEF_KEY_BYTES; i++) begin
      b = {24'd0, k[8*i +: 8]};
      sra = $signed(r) >>> 2;
      r = r ^ ((r << 5) + b + sra);
    end
    return r & HASH_MASK31;
  endfunction

  // Walks the probe chain; returns 1 on a match and gives the first empty slot.
  function automatic bit probe_chain(input logic [KEY_W-1:0] k, output int free_slot);
    int unsigned lg;
    int unsigned mask;
    int unsigned home;
    int unsigned idx;
    lg = size_cfg;
    if (lg < 1) lg = 1;
    if (lg > MAX_LG) lg = MAX_LG;
    mask = (1 << lg) - 1;
    home = key_hash(k) & mask;
    idx = home;
    free_slot = -1;
    for (int unsigned n = 0; n <= mask; n++) begin
      if (!tbl_used[idx]) begin
        free_slot = idx;
        return 1'b0;
      end
      if (tbl_key[idx] == k) return 1'b1;
      idx = (idx + stride_cfg) & mask;
      if (idx == home) return 1'b0;
    end
    return 1'b0;
  endfunction

  // Applies one request to the shadow table and returns the response it should get.
  function automatic outcome_t set_outcome(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
    outcome_t o;
    int free_slot;
    o.status = ST_NOT_FOUND;
    case (op)
      OP_ADD: begin
        if (k == '0) begin
          o.status = ST_NULL;
        end else if (probe_chain(k, free_slot)) begin
          o.status = ST_PRESENT;
        end else if (free_slot >= 0) begin
          tbl_key[free_slot] = k;
          tbl_used[free_slot] = 1'b1;
          stored = stored + 1'b1;
          o.status = ST_ADDED;
        end else begin
          o.status = ST_FULL;
        end
      end
      OP_TEST: begin
        if (k != '0 && stored != 0 && probe_chain(k, free_slot)) o.status = ST_FOUND;
      end
      OP_CLEAR: begin
        for (int i = 0; i < DEF_TABLE_DEPTH; i++) tbl_used[i] = 1'b0;
        stored = '0;
        o.status = ST_CLEARED;
      end
      default: begin
      end
    endcase
    o.count = stored;
    return o;
  endfunction

  task automatic push_req(input logic [OP_W-1:0] op, input logic [KEY_W-1:0] k);
    set_req_t r;
    r.op = op;
    r.key = k;
    req_q.push_back(r);
    if (op == OP_ADD && k != '0) begin
      key_pool.push_back(k);
      if (key_pool.size() > 64) void'(key_pool.pop_front());
    end
  endtask

  // Keys mix reuse of earlier keys, the null key, corner patterns and full random values.
  function automatic logic [KEY_W-1:0] pick_key();
    int r;
    logic [KEY_W-1:0] bit_one;
    r = $urandom_range(99);
    bit_one = 64'd1 << $urandom_range(63);
    if (r < 5) return '0;
    if (r < 45 && key_pool.size() > 0) return key_pool[$urandom_range(key_pool.size() - 1)];
    if (r < 47) return '1;
    if (r < 49) return bit_one;
    if (r < 51) return ~bit_one;
    return {$urandom, $urandom};
  endfunction

  // Waits until no request is pending or in flight and every response has come.
  task automatic wait_drained();
    @(negedge clk);
    while (req_q.size() != 0 || req_ch.valid || outcome_q.size() != 0) @(negedge clk);
  endtask

  task automatic set_table(input logic [SIZE_W-1:0] lg, input logic [STRIDE_W-1:0] stride);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= REG_SIZE_LOG2;
    cfg_data  <= CFG_DATA_W'(lg);
    @(posedge clk);
    cfg_index <= REG_PROBE_STRIDE;
    cfg_data  <= stride;
    @(posedge clk);
    cfg_we <= 1'b0;
    size_cfg = lg;
    stride_cfg = stride;
    @(negedge clk);
  endtask

  // Request driver: presents queued requests and predicts each one as it is taken.
  always @(posedge clk) begin
    if (rst) begin
      req_ch.valid <= 1'b0;
    end else begin
      if (req_ch.valid && req_ch.ready) begin
        outcome_q.push_back(set_outcome(req_ch.operation, req_ch.key));
        accepted_reqs++;
      end
      if (!req_ch.valid || req_ch.ready) begin
        if (req_q.size() > 0 &&
            ((accepted_reqs >= CALM_FIRST && accepted_reqs < CALM_LAST) ||
             $urandom_range(99) >= 30)) begin
          set_req_t r;
          r = req_q.pop_front();
          req_ch.valid     <= 1'b1;
          req_ch.operation <= r.op;
          req_ch.key       <= r.key;
        end else begin
          req_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Response monitor: compares each response with the oldest prediction.
  always @(posedge clk) begin
    if (rst) begin
      rsp_ch.ready <= 1'b0;
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (outcome_q.size() == 0) begin
          $error("response with no request outstanding: status %0d count %0d",
                 rsp_ch.status, rsp_ch.count);
          failures++;
        end else begin
          outcome_t want;
          want = outcome_q.pop_front();
          if (rsp_ch.status !== want.status) begin
            $error("status: expected %0d, actual %0d", want.status, rsp_ch.status);
            failures++;
          end
          if (rsp_ch.count !== want.count) begin
            $error("count: expected %0d, actual %0d", want.count, rsp_ch.count);
            failures++;
          end
        end
        checked_rsps++;
      end
      rsp_ch.ready <= (checked_rsps >= CALM_FIRST && checked_rsps < CALM_LAST) ||
                      $urandom_range(99) >= 30;
    end
  end

  // Stimulus: directed requests, then phases of random requests under varied settings.
  initial begin
    logic [SIZE_W-1:0]   lg;
    logic [STRIDE_W-1:0] st;
    int r;
    clk = 1'b0;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    req_ch.valid = 1'b0;
    req_ch.operation = '0;
    req_ch.key = '0;
    rsp_ch.ready = 1'b0;
    accepted_reqs = 0;
    checked_rsps = 0;
    failures = 0;
    stored = '0;
    size_cfg = SIZE_LOG2_RESET;
    stride_cfg = STRIDE_RESET;
    for (int i = 0; i < DEF_TABLE_DEPTH; i++) begin
      tbl_used[i] = 1'b0;
      tbl_key[i] = '0;
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // Reset settings: empty set, null key, duplicates, extreme keys, unknown operation, a clear.
    push_req(OP_TEST, 64'd5);
    push_req(OP_ADD, '0);
    push_req(OP_TEST, '0);
    push_req(OP_ADD, 64'd1);
    push_req(OP_ADD, '1);
    push_req(OP_ADD, 64'd1);
    push_req(OP_TEST, 64'd1);
    push_req(OP_TEST, 64'h8000_0000_0000_0000);
    push_req(OP_UNKNOWN, '1);
    push_req(OP_CLEAR, 64'd1);
    push_req(OP_TEST, 64'd1);

    // Two slots: the third add finds the table full, and a test walks the whole chain.
    wait_drained();
    set_table(4'd1, 10'd1);
    push_req(OP_ADD, 64'd11);
    push_req(OP_ADD, 64'd22);
    push_req(OP_ADD, 64'd33);
    push_req(OP_TEST, 64'd33);
    push_req(OP_TEST, 64'd11);
    push_req(OP_CLEAR, '0);

    // Zero stride probes the home slot alone.
    wait_drained();
    set_table(4'd2, 10'd0);
    push_req(OP_ADD, 64'h0123_4567_89ab_cdef);
    push_req(OP_ADD, 64'hfedc_ba98_7654_3210);
    push_req(OP_ADD, 64'h5555_aaaa_5555_aaaa);
    push_req(OP_ADD, 64'haaaa_5555_aaaa_5555);
    push_req(OP_TEST, 64'h5555_aaaa_5555_aaaa);

    // Random phases; keys left from one phase carry over into the next setting.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin lg = 4'd10; st = 10'd1;    end
        1: begin lg = 4'd1;  st = 10'd1023; end
        2: begin lg = 4'd4;  st = 10'd0;    end
        3: begin lg = 4'd0;  st = 10'd2;    end
        4: begin lg = 4'd15; st = 10'd512;  end
        5: begin lg = 4'd3;  st = 10'd7;    end
        6: begin lg = 4'd10; st = 10'd1023; end
        7: begin lg = 4'd2;  st = 10'd5;    end
        8: begin lg = 4'd6;  st = 10'd3;    end
        default: begin
          lg = $urandom_range(15);
          st = $urandom_range(1023);
          if ($urandom_range(3) != 0) st[0] = 1'b1;
        end
      endcase
      wait_drained();
      set_table(lg, st);
      for (int n = 0; n < RANDOM_ITEMS / PHASES; n++) begin
        r = $urandom_range(99);
        if (r < 3) push_req(OP_CLEAR, {$urandom, $urandom});
        else if (r < 6) push_req(OP_UNKNOWN, pick_key());
        else if (r < 52) push_req(OP_ADD, pick_key());
        else push_req(OP_TEST, pick_key());
      end
    end

    wait_drained();
    repeat (30) @(posedge clk);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // Run limit, far above the slowest legal run including the clearing sweep after reset.
  initial begin
    #(64'd12_000_000);
    $display("== FAIL ==");
    $finish;
  end

endmodule
